FILE: rtl/core/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared constants, codes and widths of the fully connected layer.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int unsigned DATA_WIDTH  = 16;
  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned MAX_INPUTS  = 64;
  localparam int unsigned MAX_OUTPUTS = 32;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned ROW_W     = 7;
  localparam int unsigned COL_W     = 5;
  localparam int unsigned IN_CNT_W  = 7;
  localparam int unsigned OUT_CNT_W = 6;

  // weight rows 0..MAX_INPUTS-1 plus the bias row, MAX_OUTPUTS columns each
  localparam int unsigned W_DEPTH    = (MAX_INPUTS + 1) * MAX_OUTPUTS;
  localparam int unsigned W_ADDR_W   = ROW_W + COL_W;
  localparam int unsigned I_DEPTH    = MAX_INPUTS;
  localparam int unsigned I_ADDR_W   = $clog2(MAX_INPUTS);

  localparam int unsigned PROD_W = 2 * DATA_WIDTH;
  localparam int unsigned ACC_W  = 2 * DATA_WIDTH + $clog2(MAX_INPUTS + 1) + 1;
  localparam int unsigned SH_W   = ACC_W - FRAC_BITS;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register select is paddr bit 2
  localparam logic REG_IN_COUNT  = 1'b0;
  localparam logic REG_OUT_COUNT = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_WEIGHT = 2'd0,
    MODE_WR_INPUT  = 2'd1,
    MODE_EVAL      = 2'd2
  } mode_e;

  typedef logic [MODE_W-1:0]            mode_t;
  typedef logic [ROW_W-1:0]             row_t;
  typedef logic [COL_W-1:0]             col_t;
  typedef logic signed [DATA_WIDTH-1:0] data_t;

  localparam data_t SAT_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam data_t SAT_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

endpackage

FILE: rtl/core/fcl_if.sv
// ----------------------------------------------------------------------------
// fcl_in_if / fcl_out_if
// Valid/ready channels carrying layer commands and layer results.
// ----------------------------------------------------------------------------
interface fcl_in_if;
  import fcl_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  row_t  row;
  col_t  col;
  data_t value;

  modport source (output valid, output mode, output row, output col, output value,
                  input ready);
  modport sink   (input valid, input mode, input row, input col, input value,
                  output ready);
endinterface

interface fcl_out_if;
  import fcl_pkg::*;

  logic  valid;
  logic  ready;
  col_t  out_index;
  data_t out_value;
  logic  saturated;
  logic  last;

  modport source (output valid, output out_index, output out_value, output saturated,
                  output last, input ready);
  modport sink   (input valid, input out_index, input out_value, input saturated,
                  input last, output ready);
endinterface

FILE: rtl/core/fully_connected_layer.sv
// ----------------------------------------------------------------------------
// fully_connected_layer
// Fixed-point (Q4.12) fully connected layer with bias, stores held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries commands. Mode 0 writes one weight word at (row, col), row 64
//   being the bias row; mode 1 writes one input element; mode 2 evaluates the
//   layer. Writes produce nothing on out_o.
//   An evaluation streams out_count results on out_o in index order, the last
//   one flagged. Each result takes one weight/input RAM read per term (bias
//   first) through the single read port of each RAM, then multiply,
//   accumulate and scale/saturate stages.
//   in_i.ready is high only while no evaluation is in progress, so a command
//   waits until the final result of the previous evaluation has transferred.
//   A stalled receiver holds the current result; the next output does not
//   start accumulating until the output register is free.
//   The APB port holds in_count (address 0) and out_count (address 4); write
//   them only while idle. Reset sets in_count to 64 and out_count to 32; the
//   RAM contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module fully_connected_layer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  fcl_in_if.sink                          in_i,
  fcl_out_if.source                       out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcl_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [fcl_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import fcl_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [IN_CNT_W-1:0]  in_count_q, in_count_d;
  logic [OUT_CNT_W-1:0] out_count_q, out_count_d;
  row_t                 row_q, row_d;
  col_t                 col_q, col_d;
  logic                 bias_q, bias_d;
  logic                 pend_q, pend_d;

  logic s1_vld_q, s1_bias_q, s1_last_q;
  logic s2_vld_q, s2_bias_q, s2_last_q;
  logic s3_done_q;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;

  logic  out_valid_q, out_valid_d;
  col_t  out_index_q;
  data_t out_value_q;
  logic  out_sat_q, out_last_q;

  // ---------------------------------------------------------------- config
  logic                  cfg_wr;
  logic [IN_CNT_W-1:0]   cfg_in_raw;
  logic [OUT_CNT_W-1:0]  cfg_out_raw;

  assign pready      = 1'b1;
  assign cfg_wr      = psel & penable & pwrite;
  assign cfg_in_raw  = pwdata[IN_CNT_W-1:0];
  assign cfg_out_raw = pwdata[OUT_CNT_W-1:0];

  always_comb begin
    in_count_d  = in_count_q;
    out_count_d = out_count_q;
    if (cfg_wr && paddr[2] == REG_IN_COUNT) begin
      if (cfg_in_raw == '0) begin
        in_count_d = IN_CNT_W'(1);
      end else if (cfg_in_raw > IN_CNT_W'(MAX_INPUTS)) begin
        in_count_d = IN_CNT_W'(MAX_INPUTS);
      end else begin
        in_count_d = cfg_in_raw;
      end
    end
    if (cfg_wr && paddr[2] == REG_OUT_COUNT) begin
      if (cfg_out_raw == '0) begin
        out_count_d = OUT_CNT_W'(1);
      end else if (cfg_out_raw > OUT_CNT_W'(MAX_OUTPUTS)) begin
        out_count_d = OUT_CNT_W'(MAX_OUTPUTS);
      end else begin
        out_count_d = cfg_out_raw;
      end
    end
  end

  assign prdata = (paddr[2] == REG_OUT_COUNT) ? CFG_DATA_W'(out_count_q)
                                               : CFG_DATA_W'(in_count_q);

  // ---------------------------------------------------------------- stores
  logic                in_xfer;
  logic                w_we, i_we;
  logic [W_ADDR_W-1:0] w_waddr, w_raddr;
  logic [DATA_WIDTH-1:0] w_rdata, i_rdata;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid & in_i.ready;

  assign w_we    = in_xfer && (in_i.mode == MODE_WR_WEIGHT) &&
                   (in_i.row <= ROW_W'(MAX_INPUTS));
  assign i_we    = in_xfer && (in_i.mode == MODE_WR_INPUT) &&
                   (in_i.row < ROW_W'(MAX_INPUTS));
  assign w_waddr = {in_i.row, in_i.col};
  assign w_raddr = {(bias_q ? ROW_W'(MAX_INPUTS) : row_q), col_q};

  fcl_ram #(
    .Width (DATA_WIDTH),
    .Depth (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (in_i.value),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  fcl_ram #(
    .Width (DATA_WIDTH),
    .Depth (I_DEPTH)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (in_i.row[I_ADDR_W-1:0]),
    .wdata_i (in_i.value),
    .raddr_i (row_q[I_ADDR_W-1:0]),
    .rdata_o (i_rdata)
  );

  // ---------------------------------------------------------------- sequencer
  logic issue, issue_last, out_free, load, last_out;

  assign issue      = (state_q == ST_ISSUE);
  assign issue_last = issue && !bias_q && (ROW_W'(row_q + 1'b1) == ROW_W'(in_count_q));
  assign out_free   = !out_valid_q || out_o.ready;
  assign last_out   = (OUT_CNT_W'(col_q) + 1'b1) == out_count_q;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    bias_d  = bias_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_i.mode == MODE_EVAL) begin
          state_d = ST_ISSUE;
          col_d   = '0;
          row_d   = '0;
          bias_d  = 1'b1;
        end
      end
      ST_ISSUE: begin
        if (bias_q) begin
          bias_d = 1'b0;
        end else if (issue_last) begin
          state_d = ST_WAIT;
          pend_d  = 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_WAIT: begin
        // hold the next output until the result register can take it
        if (!pend_q && out_free) begin
          if (last_out) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            col_d   = col_q + 1'b1;
            row_d   = '0;
            bias_d  = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (load) begin
      pend_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- datapath
  data_t                    w_sgn, i_sgn;
  logic signed [PROD_W-1:0] bias_ext, mul;
  logic signed [SH_W-1:0]   shifted;
  logic [SH_W-DATA_WIDTH:0] hi_bits;
  logic                     ovf;
  data_t                    res_value;

  assign w_sgn    = w_rdata;
  assign i_sgn    = i_rdata;
  assign bias_ext = PROD_W'(w_sgn);
  assign mul      = i_sgn * w_sgn;
  assign prod_d   = s1_bias_q ? (bias_ext <<< FRAC_BITS) : mul;
  assign acc_d    = s2_bias_q ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);

  // floor shift, then clip to the data width
  assign shifted   = acc_q[ACC_W-1:FRAC_BITS];
  assign hi_bits   = shifted[SH_W-1:DATA_WIDTH-1];
  assign ovf       = !((&hi_bits) || !(|hi_bits));
  assign res_value = ovf ? (shifted[SH_W-1] ? SAT_MIN : SAT_MAX)
                         : shifted[DATA_WIDTH-1:0];

  assign load        = s3_done_q;
  assign out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= prod_d;
    end
    if (s2_vld_q) begin
      acc_q <= acc_d;
    end
    if (load) begin
      out_index_q <= col_q;
      out_value_q <= res_value;
      out_sat_q   <= ovf;
      out_last_q  <= last_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_count_q  <= IN_CNT_W'(MAX_INPUTS);
      out_count_q <= OUT_CNT_W'(MAX_OUTPUTS);
      row_q       <= '0;
      col_q       <= '0;
      bias_q      <= 1'b0;
      pend_q      <= 1'b0;
      s1_vld_q    <= 1'b0;
      s1_bias_q   <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_vld_q    <= 1'b0;
      s2_bias_q   <= 1'b0;
      s2_last_q   <= 1'b0;
      s3_done_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_count_q  <= in_count_d;
      out_count_q <= out_count_d;
      row_q       <= row_d;
      col_q       <= col_d;
      bias_q      <= bias_d;
      pend_q      <= pend_d;
      s1_vld_q    <= issue;
      s1_bias_q   <= bias_q;
      s1_last_q   <= issue_last;
      s2_vld_q    <= s1_vld_q;
      s2_bias_q   <= s1_bias_q;
      s2_last_q   <= s1_vld_q & s1_last_q;
      s3_done_q   <= s2_vld_q & s2_last_q;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_index = out_index_q;
  assign out_o.out_value = out_value_q;
  assign out_o.saturated = out_sat_q;
  assign out_o.last      = out_last_q;

endmodule

FILE: rtl/core/fcl_ram.sv
// ----------------------------------------------------------------------------
// fcl_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fcl_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fcl_checker.sv
// ----------------------------------------------------------------------------
// fcl_checker
// Port-level checks of the fully connected layer, bound to the top level.
// ----------------------------------------------------------------------------
module fcl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic [fcl_pkg::MODE_W-1:0]    in_mode_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [fcl_pkg::DATA_WIDTH-1:0] out_value_i,
  input logic                          out_last_i
);
  import fcl_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i))
    else $error("stalled result changed");

  // an evaluation command blocks further commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_mode_i == MODE_EVAL |=> !in_ready_i)
    else $error("command accepted during evaluation");

  // no command is taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("ready while a result is pending");

  // more results follow a result that is not the last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> !in_ready_i)
    else $error("idle before the last result");

  // the last result transfer returns the block to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> in_ready_i)
    else $error("not idle after the last result");

endmodule

bind fully_connected_layer fcl_checker u_fcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.out_value),
  .out_last_i  (out_o.last)
);

FILE: tb/tb_fully_connected_layer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fully_connected_layer
// Self-checking bench for the Q4.12 fully connected layer. Commands go in on
// the valid/ready command channel, and the in_count/out_count registers are
// set over APB between phases. A scoreboard holds its own copy of the weight
// and input stores and predicts every neuron result of an evaluation. Each
// result is checked in order as it transfers. Directed cases come first
// (saturation, floor rounding, ignored writes, register clamping), then
// random phases over several layer shapes with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_fully_connected_layer;
  import fcl_pkg::*;

  localparam int unsigned TOTAL_ITEMS    = 360;
  localparam int unsigned PHASE_ITEMS    = 40;
  localparam int unsigned DRAIN_CYCLES   = MAX_INPUTS + 8;
  localparam int unsigned WATCHDOG_LIMIT = 20 * (MAX_INPUTS + 5);
  localparam int unsigned ROW_TOP        = 2 ** ROW_W - 1;
  localparam mode_t       MODE_UNUSED    = 2'd3;

  typedef struct packed {
    col_t  index;
    data_t value;
    logic  saturated;
    logic  last;
  } neuron_t;

  class layer_scoreboard;
    data_t       weight_mem[W_DEPTH];
    bit          weight_set[W_DEPTH];
    data_t       input_mem[I_DEPTH];
    bit          input_set[I_DEPTH];
    int unsigned n_inputs;
    int unsigned n_outputs;
    neuron_t     neuron_queue[$];
    int unsigned failures;
    int unsigned evaluations;
    int unsigned neurons_checked;
    int unsigned saturations;

    function new();
      n_inputs  = MAX_INPUTS;
      n_outputs = MAX_OUTPUTS;
    endfunction

    function int unsigned pending();
      return neuron_queue.size();
    endfunction

    function void set_register(logic sel, logic [CFG_DATA_W-1:0] data);
      int unsigned v;
      if (sel == REG_IN_COUNT) begin
        v = data[IN_CNT_W-1:0];
        n_inputs = (v == 0) ? 1 : ((v > MAX_INPUTS) ? MAX_INPUTS : v);
      end else begin
        v = data[OUT_CNT_W-1:0];
        n_outputs = (v == 0) ? 1 : ((v > MAX_OUTPUTS) ? MAX_OUTPUTS : v);
      end
    endfunction

    function int unsigned register_value(logic sel);
      return (sel == REG_IN_COUNT) ? n_inputs : n_outputs;
    endfunction

    function void predict_layer();
      longint  acc;
      neuron_t n;
      evaluations++;
      for (int c = 0; c < n_outputs; c++) begin
        acc = longint'(weight_mem[MAX_INPUTS * MAX_OUTPUTS + c]) * (longint'(1) << FRAC_BITS);
        for (int r = 0; r < n_inputs; r++)
          acc += longint'(input_mem[r]) * longint'(weight_mem[r * MAX_OUTPUTS + c]);
        // arithmetic shift floors toward minus infinity
        acc = acc >>> FRAC_BITS;
        n.index     = col_t'(c);
        n.saturated = 1'b0;
        if (acc > longint'(SAT_MAX)) begin
          n.value     = SAT_MAX;
          n.saturated = 1'b1;
        end else if (acc < longint'(SAT_MIN)) begin
          n.value     = SAT_MIN;
          n.saturated = 1'b1;
        end else begin
          n.value = data_t'(acc);
        end
        n.last = (c + 1 == n_outputs);
        neuron_queue.push_back(n);
      end
    endfunction

    function void note_command(mode_t m, row_t r, col_t c, data_t v);
      int unsigned idx;
      idx = r * MAX_OUTPUTS + c;
      case (m)
        MODE_WR_WEIGHT: begin
          if (r <= MAX_INPUTS) begin
            weight_mem[idx] = v;
            weight_set[idx] = 1'b1;
          end
        end
        MODE_WR_INPUT: begin
          if (r < MAX_INPUTS) begin
            input_mem[r] = v;
            input_set[r] = 1'b1;
          end
        end
        MODE_EVAL: predict_layer();
        default: ;
      endcase
    endfunction

    function void check_result(col_t idx, data_t val, logic sat, logic lst);
      neuron_t want;
      if (neuron_queue.size() == 0) begin
        $display("%0t: unexpected output: index %0d value %0d sat %0b last %0b",
                 $time, idx, $signed(val), sat, lst);
        failures++;
        return;
      end
      want = neuron_queue.pop_front();
      neurons_checked++;
      if (want.saturated) saturations++;
      if (idx !== want.index || val !== want.value || sat !== want.saturated ||
          lst !== want.last) begin
        $display("%0t: output mismatch: expected index %0d value %0d sat %0b last %0b",
                 $time, want.index, $signed(want.value), want.saturated, want.last);
        $display("%0t:                  actual   index %0d value %0d sat %0b last %0b",
                 $time, idx, $signed(val), sat, lst);
        failures++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  fcl_in_if  in_if ();
  fcl_out_if out_if ();

  layer_scoreboard sb;
  bit              gaps_on;
  int unsigned     commands_sent;
  int unsigned     shapes_run;

  fully_connected_layer i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic data_t rand_value();
    case ($urandom_range(0, 3))
      0: return data_t'($urandom);
      1: return data_t'(int'($urandom_range(0, 1024)) - 512);
      2: begin
        case ($urandom_range(0, 4))
          0: return SAT_MAX;
          1: return SAT_MIN;
          2: return '0;
          3: return '1;
          default: return data_t'(1);
        endcase
      end
      default: return data_t'(int'($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  // Call at a clock edge; returns at the edge of the transfer with valid still high.
  task automatic send_command(input mode_t m, input row_t r, input col_t c, input data_t v);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.row   <= r;
    in_if.col   <= c;
    in_if.value <= v;
    do begin
      @(posedge clk);
    end while (in_if.ready !== 1'b1);
    commands_sent++;
    sb.note_command(m, r, c, v);
  endtask

  // Write every store entry that the next evaluation reads and that is still unwritten.
  task automatic fill_missing();
    for (int c = 0; c < sb.n_outputs; c++)
      if (!sb.weight_set[MAX_INPUTS * MAX_OUTPUTS + c])
        send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS), col_t'(c), rand_value());
    for (int r = 0; r < sb.n_inputs; r++) begin
      if (!sb.input_set[r])
        send_command(MODE_WR_INPUT, row_t'(r), col_t'($urandom), rand_value());
      for (int c = 0; c < sb.n_outputs; c++)
        if (!sb.weight_set[r * MAX_OUTPUTS + c])
          send_command(MODE_WR_WEIGHT, row_t'(r), col_t'(c), rand_value());
    end
  endtask

  task automatic evaluate();
    fill_missing();
    send_command(MODE_EVAL, row_t'($urandom), col_t'($urandom), data_t'($urandom));
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (pready !== 1'b1);
    sb.set_register(sel, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_read_check(input logic sel);
    logic [CFG_DATA_W-1:0] want;
    want    = sb.register_value(sel);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {sel, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(posedge clk);
    end while (pready !== 1'b1);
    if (prdata !== want) begin
      $display("%0t: register %0d readback: expected %0d actual %0d",
               $time, sel, want, prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] ins, input logic [CFG_DATA_W-1:0] outs);
    wait_idle();
    cfg_write(REG_IN_COUNT, ins);
    cfg_write(REG_OUT_COUNT, outs);
    cfg_read_check(REG_IN_COUNT);
    cfg_read_check(REG_OUT_COUNT);
    shapes_run++;
  endtask

  // Mostly well-formed writes inside the active shape, some evaluations, some noise.
  task automatic random_command();
    int unsigned kind;
    row_t        r;
    col_t        c;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      if ($urandom_range(0, 7) == 0)      r = row_t'(MAX_INPUTS);
      else if ($urandom_range(0, 7) == 0) r = row_t'($urandom_range(0, MAX_INPUTS - 1));
      else                                r = row_t'($urandom_range(0, sb.n_inputs - 1));
      c = ($urandom_range(0, 7) == 0) ? col_t'($urandom)
                                      : col_t'($urandom_range(0, sb.n_outputs - 1));
      send_command(MODE_WR_WEIGHT, r, c, rand_value());
    end else if (kind < 70) begin
      r = ($urandom_range(0, 7) == 0) ? row_t'($urandom_range(0, MAX_INPUTS - 1))
                                      : row_t'($urandom_range(0, sb.n_inputs - 1));
      send_command(MODE_WR_INPUT, r, col_t'($urandom), rand_value());
    end else if (kind < 85) begin
      evaluate();
    end else begin
      case ($urandom_range(0, 2))
        0: send_command(MODE_WR_WEIGHT, row_t'($urandom_range(MAX_INPUTS + 1, ROW_TOP)),
                        col_t'($urandom), rand_value());
        1: send_command(MODE_WR_INPUT, row_t'($urandom_range(MAX_INPUTS, ROW_TOP)),
                        col_t'($urandom), rand_value());
        default: send_command(MODE_UNUSED, row_t'($urandom), col_t'($urandom),
                              data_t'($urandom));
      endcase
    end
  endtask

  // result sink with random stall bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1)
        sb.check_result(out_if.out_index, out_if.out_value, out_if.saturated, out_if.last);
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // end the run when nothing transfers for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] ins;
    logic [CFG_DATA_W-1:0] outs;
    int unsigned           phase;

    sb            = new();
    gaps_on       = 1'b1;
    commands_sent = 0;
    shapes_run    = 0;
    phase         = 0;
    rst_n         <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= MODE_WR_WEIGHT;
    in_if.row     <= '0;
    in_if.col     <= '0;
    in_if.value   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then clamping of zero and over-range counts
    cfg_read_check(REG_IN_COUNT);
    cfg_read_check(REG_OUT_COUNT);
    cfg_write(REG_IN_COUNT, '0);
    cfg_read_check(REG_IN_COUNT);
    cfg_write(REG_IN_COUNT, ROW_TOP);
    cfg_read_check(REG_IN_COUNT);
    cfg_write(REG_IN_COUNT, 32'hFFFF_FF80);
    cfg_read_check(REG_IN_COUNT);
    cfg_write(REG_OUT_COUNT, '0);
    cfg_read_check(REG_OUT_COUNT);
    cfg_write(REG_OUT_COUNT, 2 ** OUT_CNT_W - 1);
    cfg_read_check(REG_OUT_COUNT);

    configure(2, 2);
    // saturate high on output 0, low on output 1
    send_command(MODE_WR_INPUT, row_t'(0), col_t'(0), SAT_MAX);
    send_command(MODE_WR_INPUT, row_t'(1), col_t'(0), SAT_MAX);
    send_command(MODE_WR_WEIGHT, row_t'(0), col_t'(0), SAT_MAX);
    send_command(MODE_WR_WEIGHT, row_t'(1), col_t'(0), SAT_MAX);
    send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS), col_t'(0), SAT_MAX);
    send_command(MODE_WR_WEIGHT, row_t'(0), col_t'(1), SAT_MIN);
    send_command(MODE_WR_WEIGHT, row_t'(1), col_t'(1), SAT_MIN);
    send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS), col_t'(1), SAT_MIN);
    evaluate();
    // a sum of minus one LSB must floor to minus one, not to zero
    send_command(MODE_WR_INPUT, row_t'(0), col_t'(0), '1);
    send_command(MODE_WR_INPUT, row_t'(1), col_t'(0), '0);
    send_command(MODE_WR_WEIGHT, row_t'(0), col_t'(0), data_t'(1));
    send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS), col_t'(0), '0);
    evaluate();
    // writes outside the stores and the unused mode must change nothing
    send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS + 1), col_t'(0), data_t'(1234));
    send_command(MODE_WR_WEIGHT, row_t'(ROW_TOP), col_t'(MAX_OUTPUTS - 1), SAT_MIN);
    send_command(MODE_WR_INPUT, row_t'(MAX_INPUTS), col_t'(0), SAT_MAX);
    send_command(MODE_WR_INPUT, row_t'(ROW_TOP), col_t'(0), SAT_MIN);
    send_command(MODE_UNUSED, row_t'(ROW_TOP), col_t'(MAX_OUTPUTS - 1), '1);
    evaluate();
    send_command(MODE_WR_WEIGHT, row_t'(MAX_INPUTS), col_t'(MAX_OUTPUTS - 1), SAT_MAX);

    while (commands_sent < TOTAL_ITEMS) begin
      case (phase)
        0: begin ins = 1;          outs = 1;           end
        1: begin ins = MAX_INPUTS; outs = 1;           end
        2: begin ins = 1;          outs = MAX_OUTPUTS; end
        default: begin
          ins  = $urandom_range(1, 12);
          outs = $urandom_range(1, 6);
          // an over-range count clamps to all inputs; keep the shape narrow
          if ($urandom_range(0, 7) == 0) begin
            ins  = $urandom_range(MAX_INPUTS + 1, ROW_TOP);
            outs = 1;
          end
          if ($urandom_range(0, 7) == 0) outs = 0;
          // upper bits lie outside the register fields
          if ($urandom_range(0, 3) == 0) ins = ins | ($urandom << IN_CNT_W);
          if ($urandom_range(0, 3) == 0) outs = outs | ($urandom << OUT_CNT_W);
        end
      endcase
      configure(ins, outs);
      gaps_on = (commands_sent < TOTAL_ITEMS * 4 / 5);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        random_command();
      end
      evaluate();
      phase++;
    end

    wait_idle();
    $display("Covered %0d layer shapes and %0d commands, %0d of them evaluations",
             shapes_run, commands_sent, sb.evaluations);
    $display("Checked %0d neuron outputs, %0d of them saturated",
             sb.neurons_checked, sb.saturations);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
